// ----- rtl/wts_pkg.sv -----
// Shared types and constants for the waveform table sequencer.
// No dependencies; imported by the core, wts_regs, wts_ctrl, wts_dp and the testbench.
package wts_pkg;

  localparam int unsigned APB_AW = 4;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_STEP    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_LOOP    = 2'd0,
    MODE_ONESHOT = 2'd1,
    MODE_NSHOT   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_RUN_MODE      = 2'd0,
    REG_CYCLE_LIMIT   = 2'd1,
    REG_TABLE_SIZE    = 2'd2,
    REG_FINISHED_HOLD = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_UPDATE,
    ST_READ,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  run_mode;
    logic [7:0]  cycle_limit;
    logic [7:0]  table_size;
    logic [31:0] finished_hold;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_step;
    logic update;
    logic restart;
    logic ram_we;
    logic ram_re;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       frozen;
    logic       div_done;
    logic       load_ok;
    logic       out_busy;
  } sts_t;

endpackage

// ----- rtl/wts_in_if.sv -----
// Input item channel: valid/ready handshake with the load/step/restart payload.
// Depends on nothing.
interface wts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  entry_index;
  logic [15:0] entry_level;
  logic [31:0] entry_hold;
  logic [7:0]  step_size;

  modport source (output valid, operation, entry_index, entry_level, entry_hold, step_size,
                  input ready);
  modport sink   (input valid, operation, entry_index, entry_level, entry_hold, step_size,
                  output ready);
endinterface

// ----- rtl/wts_out_if.sv -----
// Result item channel: valid/ready handshake with level, hold, position and frozen flag.
// Depends on nothing.
interface wts_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] level_out;
  logic [31:0] hold_out;
  logic [7:0]  position;
  logic        is_frozen;

  modport source (output valid, level_out, hold_out, position, is_frozen, input ready);
  modport sink   (input valid, level_out, hold_out, position, is_frozen, output ready);
endinterface

// ----- rtl/waveform_table_sequencer_core.sv -----
// Channel     Dir   Handshake        Payload
// in_ch_i     in    valid/ready      operation, entry_index, entry_level, entry_hold, step_size
// out_ch_o    out   valid/ready      level_out, hold_out, position, is_frozen
// apb         in    psel/penable     paddr[3:0], pwdata/prdata 32 bits, pready tied high
//
// One item at a time. A load, restart, unused operation or step of a frozen block goes
// through capture, execute, table read and result hand-off; a step also runs the
// 9-iteration bit-serial remainder and a state update before the table read.
// The result register lets the next item be accepted while a result waits; a stalled
// result delays only the hand-off of the following one. Reset clears index, pass
// count, frozen flag and registers; the table holds no reset value.
// Depends on wts_pkg, wts_in_if, wts_out_if, wts_ram, wts_regs, wts_ctrl, wts_dp.
module waveform_table_sequencer_core
  import wts_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wts_in_if.sink            in_ch_i,
  wts_out_if.source         out_ch_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  wts_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_ready_o (in_ch_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wts_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (in_ch_i.operation),
    .entry_index_i (in_ch_i.entry_index),
    .entry_level_i (in_ch_i.entry_level),
    .entry_hold_i  (in_ch_i.entry_hold),
    .step_size_i   (in_ch_i.step_size),
    .out_valid_o   (out_ch_o.valid),
    .out_ready_i   (out_ch_o.ready),
    .level_out_o   (out_ch_o.level_out),
    .hold_out_o    (out_ch_o.hold_out),
    .position_o    (out_ch_o.position),
    .is_frozen_o   (out_ch_o.is_frozen)
  );

endmodule

// ----- rtl/wts_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module wts_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/wts_regs.sv -----
// APB configuration registers: run mode, cycle limit, table size, finished hold.
// Depends on wts_pkg.
module wts_regs
  import wts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr_en;

  assign sel    = reg_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        REG_RUN_MODE:      cfg_d.run_mode      = pwdata[1:0];
        REG_CYCLE_LIMIT:   cfg_d.cycle_limit   = pwdata[7:0];
        REG_TABLE_SIZE:    cfg_d.table_size    = pwdata[7:0];
        REG_FINISHED_HOLD: cfg_d.finished_hold = pwdata;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_RUN_MODE:      prdata = {30'd0, cfg_q.run_mode};
      REG_CYCLE_LIMIT:   prdata = {24'd0, cfg_q.cycle_limit};
      REG_TABLE_SIZE:    prdata = {24'd0, cfg_q.table_size};
      REG_FINISHED_HOLD: prdata = cfg_q.finished_hold;
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_mode      <= MODE_LOOP;
      cfg_q.cycle_limit   <= 8'd1;
      cfg_q.table_size    <= 8'd1;
      cfg_q.finished_hold <= 32'hFFFF_FFFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/wts_ctrl.sv -----
// Controller FSM: sequences capture, table write, remainder iterations, state
// update, table read and result hand-off. Depends on wts_pkg.
module wts_ctrl
  import wts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts_i.op == OP_STEP && !sts_i.frozen) state_d = ST_DIV;
        else                                      state_d = ST_READ;
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_UPDATE;
      end
      ST_UPDATE: state_d = ST_READ;
      ST_READ:   state_d = ST_OUT;
      ST_OUT: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.ram_we    = (sts_i.op == OP_LOAD) && sts_i.load_ok;
        cmd_o.restart   = (sts_i.op == OP_RESTART);
        cmd_o.div_start = (sts_i.op == OP_STEP) && !sts_i.frozen;
      end
      ST_DIV:    cmd_o.div_step = !sts_i.div_done;
      ST_UPDATE: cmd_o.update   = 1'b1;
      ST_READ:   cmd_o.ram_re   = 1'b1;
      ST_OUT:    cmd_o.out_load = !sts_i.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/wts_dp.sv -----
// Datapath: item registers, index/pass/frozen state, bit-serial remainder unit,
// waveform table RAM and result register. Depends on wts_pkg and wts_ram.
module wts_dp
  import wts_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  entry_index_i,
  input  logic [15:0] entry_level_i,
  input  logic [31:0] entry_hold_i,
  input  logic [7:0]  step_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] level_out_o,
  output logic [31:0] hold_out_o,
  output logic [7:0]  position_o,
  output logic        is_frozen_o
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam logic [8:0]  DEPTH = 9'(TABLE_DEPTH);

  // item payload
  logic [1:0]  op_q;
  logic [7:0]  idx_q;
  logic [15:0] lvl_q;
  logic [31:0] hold_q;
  logic [7:0]  step_q;

  // sequencer state
  logic [7:0] cur_q, cur_d;
  logic [7:0] pass_q, pass_d;
  logic       frozen_q, frozen_d;

  // remainder unit
  logic [8:0] sum_q, sum_d;
  logic [8:0] rem_q, rem_d;
  logic [3:0] cnt_q, cnt_d;
  logic       wrap_q, wrap_d;

  logic [8:0] sz, sz_m1, sum_now, rem_sh;
  logic [7:0] pass_inc;

  // result register
  logic        out_valid_q;
  logic [15:0] level_q;
  logic [31:0] hold_out_q;
  logic [7:0]  pos_q;
  logic        frz_q;

  logic [47:0] rd_data;
  logic [31:0] hold_sel;

  // size in use: table_size clamped to 1..TABLE_DEPTH
  always_comb begin
    if (cfg_i.table_size == 8'd0)          sz = 9'd1;
    else if ({1'b0, cfg_i.table_size} > DEPTH) sz = DEPTH;
    else                                    sz = {1'b0, cfg_i.table_size};
  end
  assign sz_m1   = sz - 9'd1;
  assign sum_now = {1'b0, cur_q} + {1'b0, step_q};
  assign rem_sh  = {rem_q[7:0], sum_q[8]};
  assign pass_inc = pass_q + 8'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      idx_q  <= entry_index_i;
      lvl_q  <= entry_level_i;
      hold_q <= entry_hold_i;
      step_q <= step_size_i;
    end
  end

  // restoring remainder, one dividend bit per cycle, MSB first
  always_comb begin
    sum_d  = sum_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    wrap_d = wrap_q;
    if (cmd_i.div_start) begin
      sum_d  = sum_now;
      rem_d  = 9'd0;
      cnt_d  = 4'd9;
      wrap_d = (sum_now >= sz);
    end else if (cmd_i.div_step) begin
      sum_d = {sum_q[7:0], 1'b0};
      rem_d = (rem_sh >= sz) ? (rem_sh - sz) : rem_sh;
      cnt_d = cnt_q - 4'd1;
    end
  end

  always_comb begin
    cur_d    = cur_q;
    pass_d   = pass_q;
    frozen_d = frozen_q;
    if (cmd_i.restart) begin
      cur_d  = 8'd0;
      pass_d = 8'd0;
    end else if (cmd_i.update) begin
      cur_d = rem_q[7:0];
      if (wrap_q) begin
        if (cfg_i.run_mode == MODE_ONESHOT) begin
          frozen_d = 1'b1;
        end else if (cfg_i.run_mode == MODE_NSHOT) begin
          pass_d = pass_inc;
          if (pass_inc == cfg_i.cycle_limit) frozen_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= 8'd0;
      pass_q   <= 8'd0;
      frozen_q <= 1'b0;
      cnt_q    <= 4'd0;
    end else begin
      cur_q    <= cur_d;
      pass_q   <= pass_d;
      frozen_q <= frozen_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    rem_q  <= rem_d;
    wrap_q <= wrap_d;
  end

  // table entry: hold in the upper 32 bits, level in the lower 16
  wts_ram #(
    .WIDTH (48),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (idx_q[AW-1:0]),
    .wdata_i ({hold_q, lvl_q}),
    .re_i    (cmd_i.ram_re),
    .raddr_i (cur_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign hold_sel = (cfg_i.run_mode == MODE_ONESHOT && {1'b0, cur_q} == sz_m1)
                    ? cfg_i.finished_hold : rd_data[47:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      level_q    <= rd_data[15:0];
      hold_out_q <= hold_sel;
      pos_q      <= cur_q;
      frz_q      <= frozen_q;
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.frozen   = frozen_q;
  assign sts_o.div_done = (cnt_q == 4'd0);
  assign sts_o.load_ok  = ({1'b0, idx_q} < DEPTH);
  assign sts_o.out_busy = out_valid_q & ~out_ready_i;

  assign out_valid_o = out_valid_q;
  assign level_out_o = level_q;
  assign hold_out_o  = hold_out_q;
  assign position_o  = pos_q;
  assign is_frozen_o = frz_q;

endmodule

// ----- test/wts_sequencer_checker.sv -----
// Scoreboard for the waveform table sequencer: watches the item channels and the APB port,
// predicts every result and compares it field by field. Depends on wts_pkg and the
// wts_in_if / wts_out_if interfaces.
module wts_sequencer_checker
  import wts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  wts_in_if                 in_ch,
  wts_out_if                out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] level;
    logic [31:0] hold;
    logic [7:0]  position;
    logic        frozen;
  } report_t;

  // shadow copy of the block
  logic [15:0] level_mem [256];
  logic [31:0] hold_mem  [256];
  logic [7:0]  cur_pos;
  logic [7:0]  passes;
  logic        frozen;
  logic [1:0]  run_mode;
  logic [7:0]  cycle_limit;
  logic [7:0]  table_size;
  logic [31:0] finished_hold;

  report_t reports_q [$];
  int      fails;

  function automatic report_t apply_item(input logic [1:0] op, input logic [7:0] idx,
                                         input logic [15:0] lvl, input logic [31:0] hld,
                                         input logic [7:0] step);
    logic [8:0] span;
    logic [8:0] sum;
    report_t    r;
    span = (table_size == 8'd0) ? 9'd1 : {1'b0, table_size};
    case (op)
      OP_LOAD: begin
        level_mem[idx] = lvl;
        hold_mem[idx]  = hld;
      end
      OP_STEP: begin
        if (!frozen) begin
          sum = {1'b0, cur_pos} + {1'b0, step};
          if (sum > span - 9'd1) begin
            if (run_mode == MODE_ONESHOT) begin
              frozen = 1'b1;
            end else if (run_mode == MODE_NSHOT) begin
              passes = passes + 8'd1;   // 8-bit, wraps: limit 0 means 256 passes
              if (passes == cycle_limit) frozen = 1'b1;
            end
          end
          cur_pos = 8'(sum % span);
        end
      end
      OP_RESTART: begin
        cur_pos = 8'd0;
        passes  = 8'd0;
      end
      default: ;
    endcase
    r.level    = level_mem[cur_pos];
    r.hold     = (run_mode == MODE_ONESHOT && {1'b0, cur_pos} == span - 9'd1)
                 ? finished_hold : hold_mem[cur_pos];
    r.position = cur_pos;
    r.frozen   = frozen;
    return r;
  endfunction

  task automatic flag(input string field, input logic [31:0] want, input logic [31:0] got);
    fails = fails + 1;
    if (fails <= 30)
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    report_t want;
    if (!rst_ni) begin
      cur_pos       = 8'd0;
      passes        = 8'd0;
      frozen        = 1'b0;
      run_mode      = MODE_LOOP;
      cycle_limit   = 8'd1;
      table_size    = 8'd1;
      finished_hold = 32'hFFFF_FFFF;
      reports_q.delete();
      fails         = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[3:2]))
          REG_RUN_MODE:      run_mode      = pwdata[1:0];
          REG_CYCLE_LIMIT:   cycle_limit   = pwdata[7:0];
          REG_TABLE_SIZE:    table_size    = pwdata[7:0];
          REG_FINISHED_HOLD: finished_hold = pwdata;
          default: ;
        endcase
      end
      // results first: a result at this edge belongs to an earlier item
      if (out_ch.valid && out_ch.ready) begin
        if (reports_q.size() == 0) begin
          fails = fails + 1;
          if (fails <= 30)
            $display("%0t ns: unexpected result, expected none, actual %h/%h/%h/%b", $time,
                     out_ch.level_out, out_ch.hold_out, out_ch.position, out_ch.is_frozen);
        end else begin
          want = reports_q.pop_front();
          if (out_ch.level_out !== want.level)
            flag("level", 32'(want.level), 32'(out_ch.level_out));
          if (out_ch.hold_out !== want.hold)      flag("hold", want.hold, out_ch.hold_out);
          if (out_ch.position !== want.position)
            flag("position", 32'(want.position), 32'(out_ch.position));
          if (out_ch.is_frozen !== want.frozen)
            flag("frozen", 32'(want.frozen), 32'(out_ch.is_frozen));
        end
      end
      if (in_ch.valid && in_ch.ready)
        reports_q.push_back(apply_item(in_ch.operation, in_ch.entry_index, in_ch.entry_level,
                                       in_ch.entry_hold, in_ch.step_size));
    end
    fail_count_o <= fails;
    pending_o    <= reports_q.size();
  end

endmodule

// ----- test/waveform_table_sequencer_core_test.sv -----
// Top of the sequencer testbench: clock, reset, item and APB stimulus, result back-pressure
// and the verdict. Depends on wts_pkg, the channel interfaces, the core and
// wts_sequencer_checker.
module waveform_table_sequencer_core_test;
  import wts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NONE    = 2'd3;   // unused operation code
  localparam logic [1:0] MODE_SPARE = 2'd3;   // unused mode, runs as looping
  localparam int         QUIET_LIMIT = 2000;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  wts_in_if  in_ch ();
  wts_out_if out_ch ();

  int fail_count;
  int pending;

  waveform_table_sequencer_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  wts_sequencer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // stimulus bookkeeping
  bit loaded [256];
  int span_now = 1;
  bit src_steady;
  bit sink_steady;
  int n_load, n_step, n_restart, n_none, n_settings;
  bit saw_frozen;
  int stall_left = 0;
  int quiet = 0;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result back-pressure
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
      stall_left   <= idle_len();
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready && out_ch.is_frozen) saw_frozen <= 1'b1;
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("%0t ns: nothing moved for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, pending);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send(input logic [1:0] op, input logic [7:0] idx, input logic [15:0] lvl,
                      input logic [31:0] hld, input logic [7:0] step);
    int gap;
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.entry_index <= idx;
    in_ch.entry_level <= lvl;
    in_ch.entry_hold  <= hld;
    in_ch.step_size   <= step;
    do @(posedge clk_i); while (!in_ch.ready);
    case (op)
      OP_LOAD: begin
        n_load      = n_load + 1;
        loaded[idx] = 1'b1;
      end
      OP_STEP:    n_step = n_step + 1;
      OP_RESTART: n_restart = n_restart + 1;
      default:    n_none = n_none + 1;
    endcase
    gap = src_steady ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold the sender until every result is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic reg_write(input reg_e r, input logic [31:0] v);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == REG_TABLE_SIZE) span_now = (v[7:0] == 8'd0) ? 1 : int'(v[7:0]);
  endtask

  // all four registers, then load any entry the new size brings into use
  task automatic setup(input logic [1:0] mode, input logic [7:0] limit, input logic [7:0] size,
                       input logic [31:0] fin);
    int i;
    reg_write(REG_RUN_MODE, {30'd0, mode});
    reg_write(REG_CYCLE_LIMIT, {24'd0, limit});
    reg_write(REG_TABLE_SIZE, {24'd0, size});
    reg_write(REG_FINISHED_HOLD, fin);
    n_settings = n_settings + 1;
    for (i = 0; i < span_now; i++)
      if (!loaded[i]) send(OP_LOAD, 8'(i), 16'($urandom), $urandom, 8'($urandom));
  endtask

  task automatic random_item(input bit restarts_ok);
    int         pick;
    logic [1:0] op;
    logic [7:0] idx;
    logic [7:0] step;
    pick = $urandom_range(0, 99);
    if (pick < 15)                      op = OP_LOAD;
    else if (pick < 82)                 op = OP_STEP;
    else if (pick < 92 && restarts_ok)  op = OP_RESTART;
    else if (pick >= 92)                op = OP_NONE;
    else                                op = OP_STEP;
    case ($urandom_range(0, 9))
      0:       step = 8'd0;
      1:       step = 8'($urandom_range(0, 255));
      default: step = 8'($urandom_range(1, (span_now + 1 > 255) ? 255 : span_now + 1));
    endcase
    idx = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, span_now - 1));
    send(op, idx, 16'($urandom), $urandom, step);
  endtask

  initial begin
    int p;
    int route;
    logic [1:0] mode;
    logic [7:0] size;
    logic [7:0] limit;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OP_LOAD;
    in_ch.entry_index <= 8'd0;
    in_ch.entry_level <= 16'd0;
    in_ch.entry_hold  <= 32'd0;
    in_ch.step_size   <= 8'd0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= 32'd0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes and the corner cases, reset settings first
    send(OP_LOAD, 8'h00, 16'h0000, 32'h0000_0000, 8'h00);
    send(OP_LOAD, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send(OP_STEP, 8'h5A, 16'hA5A5, 32'h1234_5678, 8'd0);       // query
    send(OP_STEP, 8'h00, 16'h0000, 32'h0000_0000, 8'd255);     // wraps on a size of one
    send(OP_NONE, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send(OP_RESTART, 8'h00, 16'h0000, 32'h0000_0000, 8'h00);
    reg_write(REG_TABLE_SIZE, 32'd0);                          // clamps to one
    send(OP_STEP, 8'h00, 16'h0000, 32'h0000_0000, 8'd1);
    setup(MODE_LOOP, 8'd1, 8'd4, 32'h0000_0000);
    send(OP_STEP, 8'h00, 16'h0000, 32'h0000_0000, 8'd3);
    send(OP_STEP, 8'h00, 16'h0000, 32'h0000_0000, 8'd255);
    reg_write(REG_RUN_MODE, {30'd0, MODE_SPARE});
    send(OP_STEP, 8'h00, 16'h0000, 32'h0000_0000, 8'd2);
    send(OP_STEP, 8'h00, 16'h0000, 32'h0000_0000, 8'd3);
    // shrink the table under the index: a query then counts a pass
    reg_write(REG_RUN_MODE, {30'd0, MODE_NSHOT});
    reg_write(REG_CYCLE_LIMIT, 32'd2);
    reg_write(REG_TABLE_SIZE, 32'd2);
    send(OP_STEP, 8'h00, 16'h0000, 32'h0000_0000, 8'd0);
    send(OP_RESTART, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    // one-shot: last entry reports the finished hold without freezing
    reg_write(REG_RUN_MODE, {30'd0, MODE_ONESHOT});
    reg_write(REG_TABLE_SIZE, 32'd4);
    reg_write(REG_FINISHED_HOLD, 32'd0);
    send(OP_STEP, 8'h00, 16'h0000, 32'h0000_0000, 8'd3);
    send(OP_STEP, 8'h00, 16'h0000, 32'h0000_0000, 8'd0);
    send(OP_LOAD, 8'd3, 16'h8001, 32'h8000_0001, 8'h00);
    send(OP_RESTART, 8'h00, 16'h0000, 32'h0000_0000, 8'h00);

    // random phases that should not freeze the sequence
    for (p = 0; p < 8; p++) begin
      case ($urandom_range(0, 2))
        0:       mode = MODE_LOOP;
        1:       mode = MODE_SPARE;
        default: mode = MODE_NSHOT;
      endcase
      if (p == 3)                          size = 8'd255;
      else if ($urandom_range(0, 5) == 0)  size = 8'd0;
      else                                 size = 8'($urandom_range(1, 16));
      if (mode == MODE_NSHOT) limit = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      else                    limit = 8'($urandom_range(0, 255));
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      setup(mode, limit, size, $urandom);
      repeat (30) random_item(1'b1);
    end

    // freezing is permanent, so one route to it per run
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    route = $urandom_range(0, 2);
    case (route)
      0: begin
        setup(MODE_ONESHOT, 8'($urandom), 8'($urandom_range(2, 8)), $urandom);
        repeat (60) random_item(1'b1);
      end
      1: begin
        setup(MODE_NSHOT, 8'($urandom_range(1, 4)), 8'($urandom_range(1, 6)), $urandom);
        repeat (60) random_item(1'b0);
      end
      default: begin
        // limit of zero: the pass counter must wrap all the way round
        setup(MODE_NSHOT, 8'd0, 8'd1, $urandom);
        repeat (260) send(OP_STEP, 8'($urandom), 16'($urandom), $urandom,
                          8'($urandom_range(1, 255)));
      end
    endcase
    setup(MODE_ONESHOT, 8'hFF, 8'd1, 32'hFFFF_FFFF);
    repeat (40) random_item(1'b1);

    settle();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d items: %0d loads, %0d steps, %0d restarts, %0d unused operations",
             n_load + n_step + n_restart + n_none, n_load, n_step, n_restart, n_none);
    $display("over %0d register settings, freeze route %0d, frozen state seen: %0d",
             n_settings, route, saw_frozen);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
